>>> sv/gpioei_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioei_pkg
// Shared types and constants of the gpio block with edge interrupts:
// port count and width, access modes, register selects and payload words.
// ----------------------------------------------------------------------------
package gpioei_pkg;

   // block size
   localparam int NUM_PORTS  = 5;
   localparam int PORT_WIDTH = 32;
   localparam int PORT_IDX_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
   localparam int EDGE_SLOTS = 2;

   // ports that carry edge detection
   localparam logic [2:0] EDGE_PORT_A = 3'd0;
   localparam logic [2:0] EDGE_PORT_B = 3'd2;

   // access modes
   localparam logic [1:0] MODE_READ   = 2'd0;
   localparam logic [1:0] MODE_WRITE  = 2'd1;
   localparam logic [1:0] MODE_SAMPLE = 2'd2;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // register selects
   localparam logic [2:0] REG_DIR       = 3'd0;
   localparam logic [2:0] REG_SET_LATCH = 3'd1;
   localparam logic [2:0] REG_CLR_PIN   = 3'd2;
   localparam logic [2:0] REG_RISE_EN   = 3'd3;
   localparam logic [2:0] REG_FALL_EN   = 3'd4;
   localparam logic [2:0] REG_RISE_STAT = 3'd5;
   localparam logic [2:0] REG_FALL_STAT = 3'd6;
   localparam logic [2:0] REG_OVERALL   = 3'd7;

   // input word
   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  port_index;
      logic [2:0]  reg_select;
      logic [31:0] write_data;
      logic [31:0] pin_levels;
   } gpioei_req_type;

   // result word
   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        irq;
      logic [31:0] drive_levels;
      logic [31:0] drive_enables;
   } gpioei_rsp_type;

   // per-port entry of the port memory
   typedef struct packed {
      logic [PORT_WIDTH-1:0] latch;
      logic [PORT_WIDTH-1:0] dir;
      logic [PORT_WIDTH-1:0] sample;
   } gpioei_port_type;

   // per-slot entry of the edge memory
   typedef struct packed {
      logic [PORT_WIDTH-1:0] rise_en;
      logic [PORT_WIDTH-1:0] fall_en;
      logic [PORT_WIDTH-1:0] rise_stat;
      logic [PORT_WIDTH-1:0] fall_stat;
   } gpioei_edge_type;

endpackage

>>> sv/gpio_ports_with_edge_interrupts.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ports_with_edge_interrupts
// Multi-port gpio block: direction, output latch with set/clear masks,
// pin-level read, and rise/fall edge status with interrupt on two ports.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one word per bus read,
//   bus write or pin sample of one port. rsp channel (rsp_valid/rsp_ready/
//   rsp_data) returns exactly one result word per request word, in order.
//   Port state sits in a small synchronous memory indexed by port; edge
//   enables and status of ports 0 and 2 sit in a second memory indexed by
//   edge slot. On acceptance the entry is read into a read register; the
//   execute state then modifies it, writes it back and loads the result
//   register. A new word is accepted only once that update is done.
//   The result register parts the channels: while a result waits, the next
//   word is still accepted and read; its update then holds until rsp_ready.
//   Reset: per-entry valid bits clear at once, so every entry reads as zero
//   (all pins inputs, latches and status clear); there is no clearing pass.
//   irq in each result reflects the edge status after that word.
// ----------------------------------------------------------------------------
module gpio_ports_with_edge_interrupts (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  gpioei_pkg::gpioei_req_type req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output gpioei_pkg::gpioei_rsp_type rsp_data
);
   import gpioei_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   gpioei_rsp_type       rsp_ff, rsp_in;
   gpioei_req_type       item_ff;
   logic [NUM_PORTS-1:0] port_vld_ff, port_vld_in;
   logic [EDGE_SLOTS-1:0] edge_vld_ff, edge_vld_in;
   logic [EDGE_SLOTS-1:0] irq_flag_ff, irq_flag_in;
   logic [EDGE_SLOTS-1:0] stat_any_ff, stat_any_in;

   // memories and their read registers
   gpioei_port_type port_mem [NUM_PORTS];
   gpioei_edge_type edge_mem [EDGE_SLOTS];
   gpioei_port_type port_rd_ff;
   gpioei_edge_type edge_rd_ff;
   logic            port_rd_vld_ff;
   logic            edge_rd_vld_ff;

   // handshake
   logic accept;
   logic exec_done;
   logic req_port_ok;
   logic req_slot;
   logic req_is_edge;

   // execute stage
   logic                  port_ok;
   logic                  is_edge;
   logic                  slot;
   logic [PORT_IDX_W-1:0] port_idx;
   logic [PORT_WIDTH-1:0] data;
   logic [PORT_WIDTH-1:0] pins;
   gpioei_port_type       cur_port, new_port;
   gpioei_edge_type       cur_edge, new_edge;
   logic [31:0]           rd;
   logic                  err;
   logic                  wr_port;
   logic                  wr_edge;
   logic [EDGE_SLOTS-1:0] irq_flag_nx;
   logic [EDGE_SLOTS-1:0] stat_any_nx;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign exec_done = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // request decode for the memory read
   assign req_port_ok = {1'b0, req_data.port_index} < 4'(NUM_PORTS);
   assign req_is_edge = (req_data.port_index == EDGE_PORT_A) ||
                        (req_data.port_index == EDGE_PORT_B);
   assign req_slot    = (req_data.port_index == EDGE_PORT_B);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (exec_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // item capture and memory read on acceptance
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
         if (req_port_ok) begin
            port_rd_ff     <= port_mem[req_data.port_index[PORT_IDX_W-1:0]];
            port_rd_vld_ff <= port_vld_ff[req_data.port_index[PORT_IDX_W-1:0]];
         end
         if (req_is_edge) begin
            edge_rd_ff     <= edge_mem[req_slot];
            edge_rd_vld_ff <= edge_vld_ff[req_slot];
         end
      end
   end

   // execute decode
   assign port_ok  = {1'b0, item_ff.port_index} < 4'(NUM_PORTS);
   assign is_edge  = (item_ff.port_index == EDGE_PORT_A) ||
                     (item_ff.port_index == EDGE_PORT_B);
   assign slot     = (item_ff.port_index == EDGE_PORT_B);
   assign port_idx = item_ff.port_index[PORT_IDX_W-1:0];
   assign data     = item_ff.write_data[PORT_WIDTH-1:0];
   assign pins     = item_ff.pin_levels[PORT_WIDTH-1:0];
   assign cur_port = port_rd_vld_ff ? port_rd_ff : '0;
   assign cur_edge = edge_rd_vld_ff ? edge_rd_ff : '0;

   // read-modify of the addressed entries
   always_comb begin
      err      = 1'b0;
      rd       = '0;
      new_port = cur_port;
      new_edge = cur_edge;
      if (!port_ok || item_ff.mode == MODE_UNUSED) begin
         err = 1'b1;
      end else if (item_ff.mode == MODE_SAMPLE) begin
         if (is_edge) begin
            new_edge.rise_stat = cur_edge.rise_stat |
                                 (~cur_port.sample & pins & cur_edge.rise_en);
            new_edge.fall_stat = cur_edge.fall_stat |
                                 (cur_port.sample & ~pins & cur_edge.fall_en);
         end
         new_port.sample = pins;
      end else if (item_ff.reg_select inside {[REG_RISE_EN:REG_FALL_STAT]} &&
                   !is_edge) begin
         err = 1'b1;
      end else if (item_ff.mode == MODE_READ) begin
         case (item_ff.reg_select)
            REG_DIR:       rd = 32'(cur_port.dir);
            REG_SET_LATCH: rd = 32'(cur_port.latch);
            REG_CLR_PIN:   rd = 32'((cur_port.latch & cur_port.dir) |
                                    (cur_port.sample & ~cur_port.dir));
            REG_RISE_EN:   rd = 32'(cur_edge.rise_en);
            REG_FALL_EN:   rd = 32'(cur_edge.fall_en);
            REG_RISE_STAT: rd = 32'(cur_edge.rise_stat);
            REG_FALL_STAT: rd = 32'(cur_edge.fall_stat);
            default:       rd = {29'd0, stat_any_ff[1], 1'b0, stat_any_ff[0]};
         endcase
      end else begin
         case (item_ff.reg_select)
            REG_DIR:       new_port.dir   = data;
            REG_SET_LATCH: new_port.latch = cur_port.latch | data;
            REG_CLR_PIN:   new_port.latch = cur_port.latch & ~data;
            REG_RISE_EN:   new_edge.rise_en = data;
            REG_FALL_EN:   new_edge.fall_en = data;
            REG_RISE_STAT: begin
               new_edge.rise_stat = cur_edge.rise_stat & ~data;
               new_edge.fall_stat = cur_edge.fall_stat & ~data;
            end
            default:       err = 1'b1;
         endcase
      end
   end

   // write enables
   assign wr_port = exec_done && !err;
   assign wr_edge = exec_done && !err && is_edge;

   // per-slot summary flags after this word
   always_comb begin
      irq_flag_nx = irq_flag_ff;
      stat_any_nx = stat_any_ff;
      if (is_edge && !err) begin
         irq_flag_nx[slot] = |((new_edge.rise_stat & new_edge.rise_en) |
                               (new_edge.fall_stat & new_edge.fall_en));
         stat_any_nx[slot] = |(new_edge.rise_stat | new_edge.fall_stat);
      end
   end

   // result word
   always_comb begin
      rsp_in.read_data     = rd;
      rsp_in.access_error  = err;
      rsp_in.irq           = |irq_flag_nx;
      rsp_in.drive_levels  = port_ok ? 32'(new_port.latch) : 32'd0;
      rsp_in.drive_enables = port_ok ? 32'(new_port.dir) : 32'd0;
   end

   // control next values
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      port_vld_in  = port_vld_ff;
      edge_vld_in  = edge_vld_ff;
      irq_flag_in  = irq_flag_ff;
      stat_any_in  = stat_any_ff;
      if (exec_done) begin
         rsp_valid_in = 1'b1;
         irq_flag_in  = irq_flag_nx;
         stat_any_in  = stat_any_nx;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (wr_port) begin
         port_vld_in[port_idx] = 1'b1;
      end
      if (wr_edge) begin
         edge_vld_in[slot] = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         port_vld_ff  <= '0;
         edge_vld_ff  <= '0;
         irq_flag_ff  <= '0;
         stat_any_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         port_vld_ff  <= port_vld_in;
         edge_vld_ff  <= edge_vld_in;
         irq_flag_ff  <= irq_flag_in;
         stat_any_ff  <= stat_any_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (exec_done) begin
         rsp_ff <= rsp_in;
      end
   end

   // memory write-back
   always_ff @(posedge clock) begin
      if (wr_port) begin
         port_mem[port_idx] <= new_port;
      end
      if (wr_edge) begin
         edge_mem[slot] <= new_edge;
      end
   end

   // a new result only comes from a finished update
   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EXEC))
      else $error("result raised without an update cycle");

   // irq in a pending result matches the summary flags
   a_irq_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.irq == (|irq_flag_ff)))
      else $error("irq of result disagrees with edge flags");

   // an invalid port never writes the memories
   a_no_bad_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) && !port_ok |-> !wr_port && !wr_edge)
      else $error("write-back on a nonexistent port");

   // a port write-back marks its entry valid
   a_port_valid: assert property (@(posedge clock) disable iff (reset)
      wr_port |=> port_vld_ff[$past(port_idx)])
      else $error("port entry not marked valid after write-back");

endmodule

>>> bench/gpioei_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpioei_checker
// Watches both channels of the gpio block, keeps its own copy of the port
// and edge state, predicts one result word per accepted request word and
// compares each returned word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module gpioei_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  gpioei_pkg::gpioei_req_type req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  gpioei_pkg::gpioei_rsp_type rsp_data,
   output int                         mismatch_count,
   output int                         pending_count,
   output int                         error_results,
   output int                         irq_results
);
   import gpioei_pkg::*;

   // shadow copy of the block state
   logic [31:0] port_latch  [NUM_PORTS];
   logic [31:0] port_dir    [NUM_PORTS];
   logic [31:0] port_sample [NUM_PORTS];
   logic [31:0] rise_enable [EDGE_SLOTS];
   logic [31:0] fall_enable [EDGE_SLOTS];
   logic [31:0] rise_status [EDGE_SLOTS];
   logic [31:0] fall_status [EDGE_SLOTS];

   gpioei_rsp_type expected_results[$];
   int mismatches;
   int pending;
   int errors_seen;
   int irqs_seen;

   assign mismatch_count = mismatches;
   assign pending_count  = pending;
   assign error_results  = errors_seen;
   assign irq_results    = irqs_seen;

   // apply one request word to the shadow state, return the result it gives
   function automatic gpioei_rsp_type predict_gpio_result(input gpioei_req_type w);
      gpioei_rsp_type r;
      int p;
      int slot;
      logic exists;
      logic [31:0] prev;
      r = '0;
      p = int'(w.port_index);
      exists = (p < NUM_PORTS);
      if (w.port_index == EDGE_PORT_A) slot = 0;
      else if (w.port_index == EDGE_PORT_B) slot = 1;
      else slot = -1;

      if (!exists || w.mode == MODE_UNUSED) begin
         r.access_error = 1'b1;
      end else if (w.mode == MODE_SAMPLE) begin
         // edges against the previous sample, edge ports only
         if (slot >= 0) begin
            prev = port_sample[p];
            rise_status[slot] |= ~prev & w.pin_levels & rise_enable[slot];
            fall_status[slot] |= prev & ~w.pin_levels & fall_enable[slot];
         end
         port_sample[p] = w.pin_levels;
      end else if (w.reg_select >= REG_RISE_EN && w.reg_select <= REG_FALL_STAT
                   && slot < 0) begin
         r.access_error = 1'b1;
      end else if (w.mode == MODE_READ) begin
         case (w.reg_select)
            REG_DIR:       r.read_data = port_dir[p];
            REG_SET_LATCH: r.read_data = port_latch[p];
            REG_CLR_PIN:   r.read_data = (port_latch[p] & port_dir[p])
                                       | (port_sample[p] & ~port_dir[p]);
            REG_RISE_EN:   r.read_data = rise_enable[slot];
            REG_FALL_EN:   r.read_data = fall_enable[slot];
            REG_RISE_STAT: r.read_data = rise_status[slot];
            REG_FALL_STAT: r.read_data = fall_status[slot];
            default: begin
               r.read_data[0] = |(rise_status[0] | fall_status[0]);
               r.read_data[2] = |(rise_status[1] | fall_status[1]);
            end
         endcase
      end else begin
         case (w.reg_select)
            REG_DIR:       port_dir[p] = w.write_data;
            REG_SET_LATCH: port_latch[p] |= w.write_data;
            REG_CLR_PIN:   port_latch[p] &= ~w.write_data;
            REG_RISE_EN:   rise_enable[slot] = w.write_data;
            REG_FALL_EN:   fall_enable[slot] = w.write_data;
            REG_RISE_STAT: begin
               rise_status[slot] &= ~w.write_data;
               fall_status[slot] &= ~w.write_data;
            end
            default:       r.access_error = 1'b1;
         endcase
      end

      r.irq = |((rise_status[0] & rise_enable[0]) | (fall_status[0] & fall_enable[0])
              | (rise_status[1] & rise_enable[1]) | (fall_status[1] & fall_enable[1]));
      if (exists) begin
         r.drive_levels  = port_latch[p];
         r.drive_enables = port_dir[p];
      end
      return r;
   endfunction

   // predict on accepted requests, compare on accepted results
   always @(posedge clock) begin : watch
      gpioei_rsp_type want;
      if (reset) begin
         for (int i = 0; i < NUM_PORTS; i++) begin
            port_latch[i]  = '0;
            port_dir[i]    = '0;
            port_sample[i] = '0;
         end
         for (int i = 0; i < EDGE_SLOTS; i++) begin
            rise_enable[i] = '0;
            fall_enable[i] = '0;
            rise_status[i] = '0;
            fall_status[i] = '0;
         end
         expected_results.delete();
         pending     = 0;
         mismatches  = 0;
         errors_seen = 0;
         irqs_seen   = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(predict_gpio_result(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.access_error) errors_seen++;
            if (rsp_data.irq) irqs_seen++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%t: result word with nothing expected:", $realtime);
                  $display("   rd=%h err=%b irq=%b lvl=%h en=%h",
                           rsp_data.read_data, rsp_data.access_error,
                           rsp_data.irq, rsp_data.drive_levels, rsp_data.drive_enables);
               end
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.read_data     !== want.read_data    ||
                   rsp_data.access_error  !== want.access_error ||
                   rsp_data.irq           !== want.irq          ||
                   rsp_data.drive_levels  !== want.drive_levels ||
                   rsp_data.drive_enables !== want.drive_enables) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%t: expected rd=%h err=%b irq=%b lvl=%h en=%h", $realtime,
                              want.read_data, want.access_error, want.irq,
                              want.drive_levels, want.drive_enables);
                     $display("%t: actual   rd=%h err=%b irq=%b lvl=%h en=%h", $realtime,
                              rsp_data.read_data, rsp_data.access_error, rsp_data.irq,
                              rsp_data.drive_levels, rsp_data.drive_enables);
                  end
               end
            end
         end
         pending = expected_results.size();
      end
   end

endmodule

>>> bench/gpio_ports_with_edge_interrupts_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_ports_with_edge_interrupts_tb
// Drives bus reads, bus writes and pin samples into the gpio block: a directed
// opening over every register, edge case and access error, then random words
// in bursts, a back-to-back stretch against a long receiver hold-off, and a
// drained pause. A separate checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module gpio_ports_with_edge_interrupts_tb;
   import gpioei_pkg::*;

   logic           clock;
   logic           reset;
   logic           req_valid;
   logic           req_ready;
   gpioei_req_type req_data;
   logic           rsp_valid;
   logic           rsp_ready;
   gpioei_rsp_type rsp_data;

   int mismatch_count;
   int pending_count;
   int error_results;
   int irq_results;
   int hold_requests;
   int words_by_mode [4];

   gpio_ports_with_edge_interrupts i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   gpioei_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .error_results  (error_results),
      .irq_results    (irq_results)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   initial begin
      #2_000_000;
      $display("run stopped: timed out with %0d result words outstanding", pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // 32-bit values biased toward all-zero, all-one, single-bit-set and single-bit-clear patterns
   function automatic logic [31:0] random_bits32();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << $urandom_range(0, 31);
         3:       return ~(32'd1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   // random request word, weighted toward the edge ports
   function automatic gpioei_req_type random_gpio_word();
      gpioei_req_type w;
      int pick;
      w.write_data = random_bits32();
      w.pin_levels = random_bits32();
      w.reg_select = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 35) w.mode = MODE_READ;
      else if (pick < 65) w.mode = MODE_WRITE;
      else if (pick < 97) w.mode = MODE_SAMPLE;
      else w.mode = MODE_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 30) w.port_index = EDGE_PORT_A;
      else if (pick < 60) w.port_index = EDGE_PORT_B;
      else if (pick < 95) w.port_index = 3'($urandom_range(0, NUM_PORTS - 1));
      else w.port_index = 3'($urandom_range(NUM_PORTS, 7));
      return w;
   endfunction

   // offer one word and hold it until accepted
   task automatic send_word(input gpioei_req_type w);
      req_data  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_by_mode[w.mode]++;
   endtask

   task automatic send_fields(input logic [1:0] mode, input logic [2:0] port,
                              input logic [2:0] sel, input logic [31:0] data,
                              input logic [31:0] pins);
      gpioei_req_type w;
      w.mode       = mode;
      w.port_index = port;
      w.reg_select = sel;
      w.write_data = data;
      w.pin_levels = pins;
      send_word(w);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // wait until every predicted result word has come back
   task automatic drain();
      idle_sender(1);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random words, either in bursts with gaps or back to back
   task automatic send_random(input int count, input bit bursty);
      int burst_left;
      burst_left = $urandom_range(1, 16);
      for (int i = 0; i < count; i++) begin
         send_word(random_gpio_word());
         if (bursty) begin
            burst_left--;
            if (burst_left == 0) begin
               idle_sender($urandom_range(1, 6));
               burst_left = $urandom_range(1, 16);
            end
         end
      end
      idle_sender(1);
   endtask

   // receiver: changing stall styles, plus a long hold-off on request
   initial begin : receiver
      int style;
      int style_left;
      int hold_left;
      int holds_served;
      logic [7:0] pattern;
      rsp_ready = 1'b0;
      style_left   = 0;
      hold_left    = 0;
      holds_served = 0;
      pattern      = 8'h5a;
      style        = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_served) begin
            holds_served++;
            hold_left = 300;
         end
         if (style_left == 0) begin
            style      = $urandom_range(0, 3);
            style_left = $urandom_range(16, 96);
            pattern    = 8'($urandom);
            if (pattern == 8'h00) pattern = 8'h5a;
         end
         style_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (style)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 3) != 0);
               2: begin
                  rsp_ready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
               default: rsp_ready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      hold_requests = 0;
      for (int i = 0; i < 4; i++) words_by_mode[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: plain port latch and pin view
      send_fields(MODE_READ,   3'd0, REG_OVERALL,   32'h0,        32'h0);
      send_fields(MODE_WRITE,  3'd1, REG_DIR,       32'hFFFF0000, 32'h0);
      send_fields(MODE_WRITE,  3'd1, REG_SET_LATCH, 32'hFFFFFFFF, 32'h0);
      send_fields(MODE_WRITE,  3'd1, REG_CLR_PIN,   32'h0000FFFF, 32'h0);
      send_fields(MODE_SAMPLE, 3'd1, REG_DIR,       32'h0,        32'hAAAAAAAA);
      send_fields(MODE_READ,   3'd1, REG_CLR_PIN,   32'h0,        32'h0);
      send_fields(MODE_READ,   3'd1, REG_SET_LATCH, 32'h0,        32'h0);
      // rise and fall edges on port 0, status read and clear
      send_fields(MODE_WRITE,  3'd0, REG_RISE_EN,   32'hFFFFFFFF, 32'h0);
      send_fields(MODE_WRITE,  3'd0, REG_FALL_EN,   32'hFFFFFFFF, 32'h0);
      send_fields(MODE_SAMPLE, 3'd0, REG_DIR,       32'h0,        32'hFFFFFFFF);
      send_fields(MODE_SAMPLE, 3'd0, REG_DIR,       32'h0,        32'h00000000);
      send_fields(MODE_READ,   3'd0, REG_RISE_STAT, 32'h0,        32'h0);
      send_fields(MODE_READ,   3'd0, REG_FALL_STAT, 32'h0,        32'h0);
      send_fields(MODE_READ,   3'd4, REG_OVERALL,   32'h0,        32'h0);
      send_fields(MODE_WRITE,  3'd0, REG_RISE_STAT, 32'hFFFFFFFF, 32'h0);
      // edges on port 2, overall status through a plain port
      send_fields(MODE_WRITE,  3'd2, REG_RISE_EN,   32'h80000001, 32'h0);
      send_fields(MODE_SAMPLE, 3'd2, REG_OVERALL,   32'hFFFFFFFF, 32'h80000001);
      send_fields(MODE_READ,   3'd3, REG_OVERALL,   32'h0,        32'h0);
      // access errors, then a port 2 status read
      send_fields(MODE_READ,   3'd1, REG_RISE_EN,   32'h0,        32'h0);
      send_fields(MODE_WRITE,  3'd2, REG_FALL_STAT, 32'hFFFFFFFF, 32'h0);
      send_fields(MODE_WRITE,  3'd0, REG_OVERALL,   32'hFFFFFFFF, 32'h0);
      send_fields(MODE_READ,   3'd5, REG_DIR,       32'h0,        32'h0);
      send_fields(MODE_SAMPLE, 3'd7, REG_DIR,       32'h0,        32'hFFFFFFFF);
      send_fields(MODE_UNUSED, 3'd0, REG_DIR,       32'hFFFFFFFF, 32'hFFFFFFFF);
      send_fields(MODE_READ,   3'd2, REG_RISE_STAT, 32'h0,        32'h0);
      drain();

      // random words in bursts, then a full pause
      send_random(300, 1'b1);
      drain();

      // back to back against a long receiver hold-off
      hold_requests++;
      send_random(200, 1'b0);

      send_random(300, 1'b1);
      drain();
      repeat (8) @(posedge clock);

      $display("run covered %0d reads, %0d writes, %0d pin samples, %0d unused-mode words",
               words_by_mode[MODE_READ], words_by_mode[MODE_WRITE],
               words_by_mode[MODE_SAMPLE], words_by_mode[MODE_UNUSED]);
      $display("results seen: %0d with access error, %0d with irq high, %0d mismatches",
               error_results, irq_results, mismatch_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
